/* rtl/sdown_pkg.sv */
package sdown_pkg;

   localparam int SAMPLE_W = 23;
   localparam int WEIGHT_W = 16;
   localparam int SUM_W    = 40;
   localparam int ADD_W    = 48;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH  = 1'd1;

   typedef enum logic [1:0] {
      CMD_ACC   = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_EMIT  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                               cmd;
      logic [3:0][SAMPLE_W-1:0]              sample;
      logic [3:0][WEIGHT_W-1:0]              weight;
   } job_type;

   // round(b * 2^22 / 255), split as b*16448 + (64b + 127) / 255
   function automatic logic [SAMPLE_W-1:0] sample_q(input logic [7:0] b);
      logic [15:0] x;
      logic [15:0] q;
      x = {2'b0, b, 6'b0} + 16'd127;
      q = (x + 16'd1 + {8'b0, x[15:8]}) >> 8;
      return SAMPLE_W'({15'b0, b} * 23'd16448) + SAMPLE_W'(q);
   endfunction

   function automatic logic [SAMPLE_W-1:0] clamp_q22(input logic signed [SUM_W-1:0] v);
      if (v < 0)
         return '0;
      if (v > 40'sd4194304)
         return 23'd4194304;
      return v[SAMPLE_W-1:0];
   endfunction

   function automatic logic [7:0] to_byte(input logic [SAMPLE_W-1:0] c);
      logic [30:0] t;
      t = ({8'b0, c} << 8) - {8'b0, c} + 31'd2097152;
      return t[29:22];
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [ADD_W-1:0] b);
      logic signed [ADD_W+1:0] s;
      s = {{(ADD_W+2-SUM_W){a[SUM_W-1]}}, a} + {{2{b[ADD_W-1]}}, b};
      if (s > 50'sd549755813887)
         return 40'sh7F_FFFF_FFFF;
      if (s < -50'sd549755813888)
         return 40'sh80_0000_0000;
      return s[SUM_W-1:0];
   endfunction

endpackage

/* rtl/sdown_front.sv */
module sdown_front import sdown_pkg::*; (
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        queue_full,
   input  logic        clearing,
   output logic        push,
   output job_type     job
);

   always_comb begin
      req_tready = !queue_full && !clearing;
      job.cmd    = cmd_type'(req_tuser);
      for (int i = 0; i < 4; i++) begin
         job.sample[i] = sample_q(req_tdata[8*i +: 8]);
         job.weight[i] = req_tdata[32 + 16*i +: 16];
      end
      // CMD_NONE items are dropped here
      push = req_tvalid && req_tready && (job.cmd != CMD_NONE);
   end

endmodule

/* rtl/sdown_queue.sv */
module sdown_queue import sdown_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   input  logic    pop,
   output job_type pop_data,
   output logic    full,
   output logic    empty
);

   job_type     slot_ff [2];
   logic        wr_ptr_ff;
   logic        rd_ptr_ff;
   logic [1:0]  count_ff;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push)
            wr_ptr_ff <= !wr_ptr_ff;
         if (pop)
            rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop)
            count_ff <= count_ff + 2'd1;
         else if (pop && !push)
            count_ff <= count_ff - 2'd1;
      end
   end

endmodule

/* rtl/sdown_back.sv */
module sdown_back import sdown_pkg::*; #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  alpha_mode,
   input  logic [CSR_DATA_W-1:0] row_width,
   input  logic                  job_valid,
   input  job_type               job,
   output logic                  pop,
   output logic                  clearing,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int COL_W  = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ADDR_W = COL_W + 4;
   localparam int DEPTH  = MAX_COLUMNS * 16;
   localparam logic [15:0] MAX_W16 = 16'(MAX_COLUMNS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE,
      S_ACC_W, S_ACC_M, S_ACC_A,
      S_CL_RD, S_CL_ADD, S_CL_WR, S_CL_FIN,
      S_EM_RD, S_EM_CAP, S_EM_PREP, S_EM_DIV, S_EM_OUT
   } state_type;

   state_type                 state_ff;
   job_type                   job_ff;
   logic [COL_W-1:0]          column_ff;
   logic [1:0]                ring_ff;
   logic [COL_W-1:0]          col_ff;
   logic                      last_ff;
   logic [3:0]                idx_ff;
   logic [ADDR_W-1:0]         clr_ff;
   logic signed [SUM_W-1:0]   lane_ff [4][4];
   logic signed [24:0]        aw_ff;
   logic signed [ADD_W-1:0]   addend_ff;
   logic signed [39:0]        ph_ff;
   logic signed [32:0]        pl_ff;
   logic [SAMPLE_W-1:0]       v_ff [4];
   logic [30:0]               rem_ff;
   logic [2:0]                step_ff;
   logic [1:0]                ch_ff;
   logic [7:0]                quo_ff [3];
   logic                      rsp_valid_ff;
   logic [31:0]               rsp_data_ff;
   logic                      rsp_last_ff;

   logic signed [SUM_W-1:0]   mem [DEPTH];
   logic signed [SUM_W-1:0]   mem_q_ff;
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_wa;
   logic signed [SUM_W-1:0]   mem_wd;
   logic [ADDR_W-1:0]         mem_ra;

   logic [COL_W-1:0]          wm1;
   logic [COL_W-1:0]          col_now;
   logic [1:0]                k;
   logic [1:0]                c;
   logic signed [WEIGHT_W-1:0] wk;
   logic signed [24:0]        mul_a;
   logic signed [23:0]        mul_b;
   logic signed [48:0]        prod;
   logic signed [48:0]        prod_r14;
   logic signed [48:0]        prod_r22;
   logic signed [SUM_W-1:0]   src;
   logic signed [56:0]        full_p;
   logic signed [56:0]        full_r14;
   logic [SAMPLE_W-1:0]       a_v;
   logic                      use_div;
   logic [30:0]               dvs;
   logic [30:0]               trial;
   logic [SAMPLE_W-1:0]       u_next;
   logic [30:0]               num_next;
   logic [1:0]                ch_sel;
   logic                      out_free;

   always_comb begin
      if (row_width == '0)
         wm1 = '0;
      else if ({3'b0, row_width} > MAX_W16)
         wm1 = COL_W'(MAX_COLUMNS - 1);
      else
         wm1 = COL_W'(row_width - 13'd1);
      col_now = (column_ff > wm1) ? wm1 : column_ff;
   end

   assign k  = idx_ff[3:2];
   assign c  = idx_ff[1:0];
   assign wk = $signed(job_ff.weight[k]);

   always_comb begin
      if (state_ff == S_ACC_W) begin
         mul_a = 25'(wk);
         mul_b = $signed({1'b0, job_ff.sample[3]});
      end else begin
         mul_a = alpha_mode ? aw_ff : 25'(wk);
         mul_b = $signed({1'b0, job_ff.sample[c]});
      end
      prod     = 49'(mul_a) * 49'(mul_b);
      prod_r14 = (prod + 49'sd8192) >>> 14;
      prod_r22 = (prod + 49'sd2097152) >>> 22;
      src      = (c == 2'd3 && !alpha_mode) ? lane_ff[0][2] : lane_ff[0][c];
      full_p   = (57'(ph_ff) <<< 16) + 57'(pl_ff);
      full_r14 = (full_p + 57'sd8192) >>> 14;
   end

   always_comb begin
      a_v      = v_ff[3];
      use_div  = alpha_mode && (a_v != '0);
      dvs      = {7'b0, a_v, 1'b0};
      trial    = dvs << step_ff;
      ch_sel   = (state_ff == S_EM_PREP) ? 2'd0 : ch_ff + 2'd1;
      u_next   = (v_ff[ch_sel] > a_v) ? a_v : v_ff[ch_sel];
      num_next = ({8'b0, u_next} << 9) - ({8'b0, u_next} << 1) + {8'b0, a_v};
      out_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = {col_ff, ring_ff, c};
      mem_wd = '0;
      mem_ra = {col_ff, ring_ff + k, c};
      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
         end
         S_CL_RD: begin
            mem_ra = {col_ff, ring_ff + k, c};
         end
         S_CL_WR: begin
            mem_we = 1'b1;
            mem_wa = {col_ff, ring_ff + k, c};
            mem_wd = sat_add(mem_q_ff, addend_ff);
         end
         S_EM_CAP: begin
            mem_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[mem_ra];
   end

   assign pop        = (state_ff == S_IDLE) && job_valid;
   assign clearing   = (state_ff == S_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         column_ff    <= '0;
         ring_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               lane_ff[i][j] <= '0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != S_EM_OUT)
            rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == ADDR_W'(DEPTH - 1))
                  state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (job_valid) begin
                  job_ff  <= job;
                  col_ff  <= col_now;
                  last_ff <= (col_now == wm1);
                  idx_ff  <= 4'd0;
                  case (job.cmd)
                     CMD_ACC:   state_ff <= S_ACC_W;
                     CMD_CLOSE: state_ff <= S_CL_RD;
                     CMD_EMIT:  state_ff <= S_EM_RD;
                     default:   state_ff <= S_IDLE;
                  endcase
               end
            end
            S_ACC_W: begin
               aw_ff    <= prod_r14[24:0];
               state_ff <= S_ACC_M;
            end
            S_ACC_M: begin
               if (c == 2'd3)
                  addend_ff <= alpha_mode ? ADD_W'(aw_ff) : '0;
               else
                  addend_ff <= alpha_mode ? prod_r22[ADD_W-1:0] : prod_r14[ADD_W-1:0];
               state_ff <= S_ACC_A;
            end
            S_ACC_A: begin
               lane_ff[k][c] <= sat_add(lane_ff[k][c], addend_ff);
               idx_ff        <= idx_ff + 4'd1;
               state_ff      <= (idx_ff == 4'd15) ? S_IDLE : S_ACC_W;
            end
            S_CL_RD: begin
               ph_ff    <= 40'(wk) * 40'($signed(src[39:16]));
               pl_ff    <= 33'(wk) * 33'($signed({1'b0, src[15:0]}));
               state_ff <= S_CL_ADD;
            end
            S_CL_ADD: begin
               addend_ff <= full_r14[ADD_W-1:0];
               state_ff  <= S_CL_WR;
            end
            S_CL_WR: begin
               idx_ff   <= idx_ff + 4'd1;
               state_ff <= (idx_ff == 4'd15) ? S_CL_FIN : S_CL_RD;
            end
            S_CL_FIN: begin
               for (int j = 0; j < 4; j++) begin
                  for (int i = 0; i < 3; i++)
                     lane_ff[i][j] <= last_ff ? '0 : lane_ff[i+1][j];
                  lane_ff[3][j] <= '0;
               end
               column_ff <= last_ff ? '0 : col_ff + 1'b1;
               state_ff  <= S_IDLE;
            end
            S_EM_RD: begin
               state_ff <= S_EM_CAP;
            end
            S_EM_CAP: begin
               v_ff[c]  <= clamp_q22(mem_q_ff);
               idx_ff   <= idx_ff + 4'd1;
               state_ff <= (c == 2'd3) ? S_EM_PREP : S_EM_RD;
            end
            S_EM_PREP: begin
               ch_ff    <= 2'd0;
               rem_ff   <= num_next;
               step_ff  <= 3'd7;
               state_ff <= use_div ? S_EM_DIV : S_EM_OUT;
            end
            S_EM_DIV: begin
               quo_ff[ch_ff][step_ff] <= (rem_ff >= trial);
               if (step_ff == 3'd0) begin
                  if (ch_ff == 2'd2) begin
                     state_ff <= S_EM_OUT;
                  end else begin
                     ch_ff   <= ch_ff + 2'd1;
                     rem_ff  <= num_next;
                     step_ff <= 3'd7;
                  end
               end else begin
                  if (rem_ff >= trial)
                     rem_ff <= rem_ff - trial;
                  step_ff <= step_ff - 3'd1;
               end
            end
            S_EM_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_last_ff  <= last_ff;
                  for (int i = 0; i < 3; i++)
                     rsp_data_ff[8*i +: 8] <= use_div ? quo_ff[i] : to_byte(v_ff[i]);
                  rsp_data_ff[31:24] <= alpha_mode ? to_byte(a_v) : 8'hFF;
                  column_ff <= last_ff ? '0 : col_ff + 1'b1;
                  if (last_ff)
                     ring_ff <= ring_ff + 2'd1;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* rtl/separable_image_downscaler.sv */
// Accumulate, close and emit commands pass through the command queue and are then worked
//   one at a time by the sequencer; RGBX and zero-alpha emits skip the divider.
// Throughput is set by the single sequencer, which works through lanes and column memory
//   one entry at a time, and in RGBA emits by the restoring divider, one colour after another.
// Reset (synchronous) clears control and lane sums, then a clearing pass over all
//   16 * MAX_COLUMNS entries zeroes the column memory; no request is accepted meanwhile.
module separable_image_downscaler import sdown_pkg::*; #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [95:0]           req_tdata,  // red, green, blue, alpha, weight0..weight3
   input  logic [1:0]            req_tuser,  // cmd
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,  // red_out, green_out, blue_out, alpha_out
   output logic                  rsp_tlast,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic                  alpha_mode_ff;
   logic [CSR_DATA_W-1:0] row_width_ff;
   logic                  push;
   logic                  pop;
   logic                  full;
   logic                  empty;
   logic                  clearing;
   job_type               push_job;
   job_type               pop_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_mode_ff <= 1'b0;
         row_width_ff  <= 13'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ALPHA_MODE: alpha_mode_ff <= csr_data[0];
            CSR_ROW_WIDTH:  row_width_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   sdown_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_full (full),
      .clearing   (clearing),
      .push       (push),
      .job        (push_job)
   );

   sdown_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .pop       (pop),
      .pop_data  (pop_job),
      .full      (full),
      .empty     (empty)
   );

   sdown_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .alpha_mode (alpha_mode_ff),
      .row_width  (row_width_ff),
      .job_valid  (!empty),
      .job        (pop_job),
      .pop        (pop),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* tb/sv/sdown_checker.sv */
`timescale 1ns / 1ps

module sdown_checker import sdown_pkg::*; #(
   parameter int MAX_COLUMNS = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [95:0]           req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [31:0]           rsp_tdata,
   input  logic                  rsp_tlast,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    pending,
   output int                    errors,
   output int                    pixels_checked
);

   localparam longint ONE_Q22 = 64'sd1 << 22;
   localparam longint SUM_HI  = (64'sd1 << 39) - 1;
   localparam longint SUM_LO  = -(64'sd1 << 39);

   logic         alpha_mode;
   logic [12:0]  row_width;
   longint       lane_acc [4][4];
   longint       col_acc  [MAX_COLUMNS][4][4];
   int           col_pos;
   logic [1:0]   ring;
   logic [32:0]  pixel_q [$];

   initial begin
      alpha_mode = 1'b0;
      row_width = 13'd1;
      col_pos = 0;
      ring = 2'd0;
      errors = 0;
      pixels_checked = 0;
      foreach (lane_acc[k, c]) lane_acc[k][c] = 0;
      foreach (col_acc[i, s, c]) col_acc[i][s][c] = 0;
   end

   assign pending = pixel_q.size();

   function automatic longint sat40(input longint v);
      if (v > SUM_HI) return SUM_HI;
      if (v < SUM_LO) return SUM_LO;
      return v;
   endfunction

   // round half up, floor semantics for negatives
   function automatic longint round_shift(input longint v, input int n);
      return (v + (64'sd1 << (n - 1))) >>> n;
   endfunction

   function automatic longint byte_to_q22(input logic [7:0] b);
      return (longint'(b) * (64'sd1 << 23) + 255) / 510;
   endfunction

   function automatic longint clip(input longint v, input longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic logic [7:0] q22_to_byte(input longint v);
      longint c;
      c = clip(v, ONE_Q22);
      return 8'((c * 255 + (64'sd1 << 21)) >>> 22);
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      errors++;
      $display("%0t sdown_checker: %s got %0d want %0d", $time, what, got, want);
   endtask

   task automatic apply_item(input logic [1:0] op, input logic [95:0] d);
      int           width, col;
      bit           last;
      longint       wt[4];
      longint       smp[4];
      longint       src[4];
      longint       aw, a, u;
      logic [7:0]   px[4];
      logic [1:0]   slot;
      width = (row_width == 0) ? 1 : (row_width > MAX_COLUMNS) ? MAX_COLUMNS : row_width;
      col = (col_pos < width) ? col_pos : width - 1;
      last = (col == width - 1);
      for (int k = 0; k < 4; k++) begin
         wt[k] = longint'($signed(d[32 + 16*k +: 16]));
         smp[k] = byte_to_q22(d[8*k +: 8]);
      end
      case (cmd_type'(op))
         CMD_ACC: begin
            for (int k = 0; k < 4; k++) begin
               if (alpha_mode) begin
                  aw = round_shift(wt[k] * smp[3], 14);
                  for (int c = 0; c < 3; c++)
                     lane_acc[k][c] = sat40(lane_acc[k][c] + round_shift(aw * smp[c], 22));
                  lane_acc[k][3] = sat40(lane_acc[k][3] + aw);
               end else begin
                  for (int c = 0; c < 3; c++)
                     lane_acc[k][c] = sat40(lane_acc[k][c] + round_shift(wt[k] * smp[c], 14));
               end
            end
         end
         CMD_CLOSE: begin
            for (int c = 0; c < 3; c++) src[c] = lane_acc[0][c];
            src[3] = alpha_mode ? lane_acc[0][3] : lane_acc[0][2];
            for (int k = 0; k < 4; k++) begin
               slot = ring + 2'(k);
               for (int c = 0; c < 4; c++)
                  col_acc[col][slot][c] =
                     sat40(col_acc[col][slot][c] + round_shift(wt[k] * src[c], 14));
            end
            if (last) begin
               foreach (lane_acc[k, c]) lane_acc[k][c] = 0;
               col_pos = 0;
            end else begin
               for (int k = 0; k < 3; k++)
                  for (int c = 0; c < 4; c++) lane_acc[k][c] = lane_acc[k + 1][c];
               for (int c = 0; c < 4; c++) lane_acc[3][c] = 0;
               col_pos = col + 1;
            end
         end
         CMD_EMIT: begin
            if (alpha_mode) begin
               a = clip(col_acc[col][ring][3], ONE_Q22);
               for (int c = 0; c < 3; c++) begin
                  if (a != 0) begin
                     u = clip(col_acc[col][ring][c], a);
                     px[c] = 8'((510 * u + a) / (2 * a));
                  end else begin
                     px[c] = q22_to_byte(col_acc[col][ring][c]);
                  end
               end
               px[3] = q22_to_byte(a);
            end else begin
               for (int c = 0; c < 3; c++) px[c] = q22_to_byte(col_acc[col][ring][c]);
               px[3] = 8'hFF;
            end
            pixel_q.push_back({last, px[3], px[2], px[1], px[0]});
            for (int c = 0; c < 4; c++) col_acc[col][ring][c] = 0;
            if (last) begin
               col_pos = 0;
               ring = ring + 2'd1;
            end else begin
               col_pos = col + 1;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      logic [32:0] want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_ALPHA_MODE)
               alpha_mode = csr_data[0];
            else if (csr_index == CSR_ROW_WIDTH)
               row_width = csr_data;
         end
         if (req_tvalid && req_tready)
            apply_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            if (pixel_q.size() == 0) begin
               report("unexpected pixel", rsp_tdata, 0);
            end else begin
               want = pixel_q.pop_front();
               pixels_checked++;
               for (int c = 0; c < 4; c++)
                  if (rsp_tdata[8*c +: 8] !== want[8*c +: 8])
                     report($sformatf("channel %0d", c), rsp_tdata[8*c +: 8], want[8*c +: 8]);
               if (rsp_tlast !== want[32])
                  report("row end", rsp_tlast, want[32]);
            end
         end
      end
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import sdown_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [95:0]           req_tdata = '0;
   logic [1:0]            req_tuser = CMD_NONE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;
   logic                  rsp_tlast;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int  pending, errors, pixels_checked;
   int  items_sent = 0;
   int  ready_hold = 0;
   bit  quiet = 1'b0;

   separable_image_downscaler uut (.*);

   sdown_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .pending, .errors, .pixels_checked
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("tb_top: errors");
      $finish;
   end

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
         rsp_tready <= 1'b1;
         ready_hold <= $urandom_range(0, 30);
      end else begin
         rsp_tready <= 1'b0;
         ready_hold <= $urandom_range(0, 13);
      end
   end

   function automatic logic [95:0] pixel(input logic [7:0] r, g, b, a,
                                         input logic [15:0] w0, w1, w2, w3);
      return {w3, w2, w1, w0, a, b, g, r};
   endfunction

   function automatic logic [15:0] any_weight();
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 16384));
   endfunction

   function automatic logic [95:0] any_pixel();
      return pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   any_weight(), any_weight(), any_weight(), any_weight());
   endfunction

   task automatic send(input cmd_type op, input logic [95:0] d);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= d;
      do @(posedge clock); while (!req_tready);
      if (op != CMD_NONE) items_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_rows(input int width, input int rows);
      for (int r = 0; r < rows; r++) begin
         for (int c = 0; c < width; c++) begin
            repeat ($urandom_range(0, 3)) send(CMD_ACC, any_pixel());
            if ($urandom_range(0, 15) == 0)
               send(cmd_type'($urandom_range(0, 3)), any_pixel());
            send(CMD_CLOSE, any_pixel());
         end
         for (int c = 0; c < width; c++) send(CMD_EMIT, any_pixel());
      end
   endtask

   initial begin
      int width;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // opaque, one column: extremes of bytes and weights
      send(CMD_ACC, pixel(8'hFF, 8'hFF, 8'hFF, 8'h00, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000));
      send(CMD_ACC, pixel(8'h00, 8'h80, 8'h01, 8'hFF, 16'h4000, 16'h4000, 16'h4000, 16'h4000));
      send(CMD_NONE, any_pixel());
      send(CMD_CLOSE, pixel(8'h00, 8'h00, 8'h00, 8'h00, 16'h4000, 16'h8000, 16'h7FFF, 16'h2000));
      send(CMD_EMIT, '0);
      send(CMD_EMIT, '0);
      send(CMD_EMIT, '0);

      // premultiplied: zero alpha, full alpha, negative slot
      write_csr(CSR_ALPHA_MODE, 13'd1);
      send(CMD_ACC, pixel(8'hFF, 8'h40, 8'h00, 8'h00, 16'h4000, 16'h4000, 16'h4000, 16'h4000));
      send(CMD_CLOSE, pixel(8'h00, 8'h00, 8'h00, 8'h00, 16'h4000, 16'h4000, 16'h4000, 16'h4000));
      send(CMD_EMIT, '0);
      send(CMD_ACC, pixel(8'hC0, 8'h40, 8'hFF, 8'hFF, 16'h4000, 16'h0000, 16'h0000, 16'h0000));
      send(CMD_ACC, pixel(8'h20, 8'hFF, 8'h00, 8'h80, 16'h4000, 16'h0000, 16'h0000, 16'h0000));
      send(CMD_CLOSE, pixel(8'h00, 8'h00, 8'h00, 8'h00, 16'h4000, 16'hC000, 16'h6000, 16'h0000));
      send(CMD_EMIT, '0);
      send(CMD_EMIT, '0);

      // widest row, then narrowed under a column index past the end
      write_csr(CSR_ROW_WIDTH, 13'd4096);
      repeat (5) send(CMD_CLOSE, any_pixel());
      send(CMD_EMIT, '0);
      write_csr(CSR_ROW_WIDTH, 13'd3);
      send(CMD_CLOSE, any_pixel());
      send(CMD_EMIT, '0);
      write_csr(CSR_ROW_WIDTH, 13'd0);
      send(CMD_CLOSE, any_pixel());
      send(CMD_EMIT, '0);
      write_csr(CSR_ROW_WIDTH, 13'd8191);
      send(CMD_EMIT, '0);

      while (items_sent < 850) begin
         if (items_sent > 700) quiet = 1'b1;
         write_csr(CSR_ALPHA_MODE, 13'($urandom_range(0, 1)));
         width = $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0) width = 0;
         write_csr(CSR_ROW_WIDTH, 13'(width));
         if (width == 0) width = 1;
         run_rows(width, $urandom_range(2, 6));
      end

      drain();
      $display("tb_top: %0d commands over both pixel modes and row widths 1 to 4096,",
               items_sent);
      $display("tb_top: %0d output pixels checked", pixels_checked);
      if (errors == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/sdown_pkg.sv
rtl/sdown_front.sv
rtl/sdown_queue.sv
rtl/sdown_back.sv
rtl/separable_image_downscaler.sv
tb/sv/sdown_checker.sv
tb/sv/tb_top.sv
